>>> rtl/core/ucdp_pkg.sv
package ucdp_pkg;

	localparam int BUFFER_BYTES = 512;

	localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
	localparam int CUR_W = $clog2(BUFFER_BYTES);
	localparam int OFF_W = $clog2(BUFFER_BYTES + 8);
	localparam int SUM_W = ((CUR_W > 8) ? CUR_W : 8) + 1;

	localparam int WIN_BYTES     = 8;
	localparam int FLUSH_STAGES  = WIN_BYTES - 1;

	localparam logic [CUR_W-1:0] HDR_LEN          = CUR_W'(9);
	localparam logic [7:0]       DEFAULT_INTERVAL = 8'd10;

	localparam logic [CNT_W-1:0] OFS_TOTAL_LO = CNT_W'(2);
	localparam logic [CNT_W-1:0] OFS_TOTAL_HI = CNT_W'(3);
	localparam logic [CNT_W-1:0] OFS_NUM_IF   = CNT_W'(4);
	localparam logic [CNT_W-1:0] OFS_CFG_VAL  = CNT_W'(5);
	localparam logic [CNT_W-1:0] OFS_ATTR     = CNT_W'(7);
	localparam logic [CNT_W-1:0] OFS_POWER    = CNT_W'(8);

	localparam logic [2:0] OFS_LEN         = 3'd0;
	localparam logic [2:0] OFS_TYPE        = 3'd1;
	localparam logic [2:0] OFS_IF_NUMBER   = 3'd2;
	localparam logic [2:0] OFS_EP_ATTR     = 3'd3;
	localparam logic [2:0] OFS_IF_CLASS    = 3'd5;
	localparam logic [2:0] OFS_IF_SUBCLASS = 3'd6;
	localparam logic [2:0] OFS_EP_INTERVAL = 3'd6;
	localparam logic [2:0] OFS_IF_PROTOCOL = 3'd7;

	localparam logic [7:0] DT_INTERFACE   = 8'd4;
	localparam logic [7:0] DT_ENDPOINT    = 8'd5;
	localparam logic [1:0] XFER_INTERRUPT = 2'd3;

	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_EP     = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	typedef logic [WIN_BYTES-1:0][7:0] window_t;

	typedef struct packed {
		logic [1:0]       phase;
		logic [CUR_W-1:0] cur;
		logic             found;
		logic [7:0]       if_number;
		logic [7:0]       if_class;
		logic [7:0]       if_subclass;
		logic [7:0]       interval;
	} walk_t;

	localparam walk_t WALK_INIT = '{
		phase:       PH_SEARCH,
		cur:         HDR_LEN,
		found:       1'b0,
		if_number:   8'd0,
		if_class:    8'd0,
		if_subclass: 8'd0,
		interval:    8'd0
	};

	typedef struct packed {
		logic [7:0]       num_if;
		logic [7:0]       cfg_val;
		logic [7:0]       attr;
		logic [7:0]       power;
		logic [15:0]      total;
		window_t          hist;
		logic [OFF_W-1:0] off;
		walk_t            walk;
	} flush_t;

endpackage

>>> rtl/core/ucdp_walk_step.sv
module ucdp_walk_step import ucdp_pkg::*; (
	input  walk_t            walk_in,
	input  window_t          win,
	input  logic [OFF_W-1:0] off,
	input  logic [15:0]      total,
	input  logic [7:0]       target,
	output walk_t            walk_out
);

	logic             hit;
	logic [SUM_W-1:0] nxt;
	logic             stop;
	logic             past_end;

	// descriptor is examined once its last field byte has been seen
	assign hit      = (walk_in.phase != PH_DONE) &&
	                  ((OFF_W'(walk_in.cur) + OFF_W'(WIN_BYTES - 1)) == off);
	assign nxt      = SUM_W'(walk_in.cur) + SUM_W'(win[OFS_LEN]);
	assign stop     = (win[OFS_LEN] == 8'd0) || (nxt >= SUM_W'(BUFFER_BYTES));
	assign past_end = 16'(walk_in.cur) >= total;

	always_comb begin
		walk_out = walk_in;
		if (hit) begin
			if (past_end) begin
				walk_out.phase = PH_DONE;
			end else begin
				case (walk_in.phase)
					PH_SEARCH: begin
						if (win[OFS_TYPE] == DT_INTERFACE && win[OFS_IF_PROTOCOL] == target) begin
							walk_out.found       = 1'b1;
							walk_out.if_number   = win[OFS_IF_NUMBER];
							walk_out.if_class    = win[OFS_IF_CLASS];
							walk_out.if_subclass = win[OFS_IF_SUBCLASS];
							walk_out.phase       = stop ? PH_DONE : PH_EP;
						end else if (stop) begin
							walk_out.phase = PH_DONE;
						end
						walk_out.cur = nxt[CUR_W-1:0];
					end
					PH_EP: begin
						if (win[OFS_TYPE] == DT_INTERFACE) begin
							walk_out.phase = PH_DONE;
						end else if (win[OFS_TYPE] == DT_ENDPOINT &&
						             win[OFS_EP_ATTR][1:0] == XFER_INTERRUPT) begin
							walk_out.interval = win[OFS_EP_INTERVAL];
							walk_out.phase    = PH_DONE;
						end else if (stop) begin
							walk_out.phase = PH_DONE;
						end else begin
							walk_out.cur = nxt[CUR_W-1:0];
						end
					end
					default: begin
						walk_out.phase = PH_DONE;
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/core/usb_config_descriptor_parser_core.sv
// Parses a USB configuration descriptor that arrives one byte per transfer on the input
// channel, with last_byte marking its final byte. A new byte is taken every cycle; the one
// result per descriptor appears on the output channel from a result register behind the
// pipeline that finishes the walk over descriptors whose fields run past the delivered
// data (read as zero). Bytes beyond the 512-byte buffer are dropped. The input stalls only
// when a finished result reaches the output register while the previous one is still
// waiting to be taken. target_protocol resets to 1 (keyboard) and is written through
// cfg_we/cfg_wdata, by the user only while no descriptor is in flight (not enforced).
module usb_config_descriptor_parser_core import ucdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       header_valid,
	output logic [7:0] interface_count,
	output logic [7:0] config_value,
	output logic [7:0] config_attributes,
	output logic [7:0] max_power,
	output logic       interface_found,
	output logic [7:0] interface_number,
	output logic [7:0] interface_class,
	output logic [7:0] interface_subclass,
	output logic [7:0] poll_interval
);

	logic [7:0]       target_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      total_q;
	logic [7:0]       num_if_q;
	logic [7:0]       cfg_val_q;
	logic [7:0]       attr_q;
	logic [7:0]       power_q;
	window_t          hist_q;
	walk_t            walk_q;

	logic             accept;
	logic             adv;
	logic             stored;
	window_t          hist_n;
	walk_t            walk_step;
	walk_t            walk_n;
	logic [15:0]      total_n;
	logic [7:0]       num_if_n;
	logic [7:0]       cfg_val_n;
	logic [7:0]       attr_n;
	logic [7:0]       power_n;
	logic [OFF_W-1:0] end_off;

	flush_t           fl_s     [FLUSH_STAGES];
	logic             fl_vld_s [FLUSH_STAGES];
	flush_t           fl_nx    [FLUSH_STAGES];

	assign adv      = !(fl_vld_s[FLUSH_STAGES-1] && out_valid && !out_ready);
	assign in_ready = adv;
	assign accept   = in_valid && in_ready;
	assign stored   = cnt_q < CNT_W'(BUFFER_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 8'd1;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	// main walk on the incoming byte
	assign hist_n = stored ? {data_byte, hist_q[WIN_BYTES-1:1]} : hist_q;

	ucdp_walk_step u_main_step (
		.walk_in  (walk_q),
		.win      (hist_n),
		.off      (OFF_W'(cnt_q)),
		.total    (total_q),
		.target   (target_q),
		.walk_out (walk_step)
	);

	always_comb begin
		walk_n    = stored ? walk_step : walk_q;
		total_n   = total_q;
		num_if_n  = num_if_q;
		cfg_val_n = cfg_val_q;
		attr_n    = attr_q;
		power_n   = power_q;
		if (stored) begin
			case (cnt_q)
				OFS_TOTAL_LO: total_n[7:0]  = data_byte;
				OFS_TOTAL_HI: total_n[15:8] = data_byte;
				OFS_NUM_IF:   num_if_n      = data_byte;
				OFS_CFG_VAL:  cfg_val_n     = data_byte;
				OFS_ATTR:     attr_n        = data_byte;
				OFS_POWER:    power_n       = data_byte;
				default: begin
				end
			endcase
		end
		end_off = stored ? OFF_W'(cnt_q) : OFF_W'(BUFFER_BYTES - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			total_q   <= '0;
			num_if_q  <= '0;
			cfg_val_q <= '0;
			attr_q    <= '0;
			power_q   <= '0;
			walk_q    <= WALK_INIT;
		end else if (accept) begin
			if (last_byte) begin
				cnt_q     <= '0;
				total_q   <= '0;
				num_if_q  <= '0;
				cfg_val_q <= '0;
				attr_q    <= '0;
				power_q   <= '0;
				walk_q    <= WALK_INIT;
			end else begin
				cnt_q     <= stored ? cnt_q + CNT_W'(1) : cnt_q;
				total_q   <= total_n;
				num_if_q  <= num_if_n;
				cfg_val_q <= cfg_val_n;
				attr_q    <= attr_n;
				power_q   <= power_n;
				walk_q    <= walk_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stored && accept && !last_byte) begin
			hist_q <= hist_n;
		end
	end

	// finishing pipeline: one zero byte past the end per stage
	genvar gi;
	generate
		for (gi = 0; gi < FLUSH_STAGES; gi++) begin : g_flush
			window_t          sh_hist;
			logic [OFF_W-1:0] sh_off;

			assign sh_hist = {8'd0, fl_s[gi].hist[WIN_BYTES-1:1]};
			assign sh_off  = fl_s[gi].off + OFF_W'(1);

			ucdp_walk_step u_flush_step (
				.walk_in  (fl_s[gi].walk),
				.win      (sh_hist),
				.off      (sh_off),
				.total    (fl_s[gi].total),
				.target   (target_q),
				.walk_out (fl_nx[gi].walk)
			);

			assign fl_nx[gi].num_if  = fl_s[gi].num_if;
			assign fl_nx[gi].cfg_val = fl_s[gi].cfg_val;
			assign fl_nx[gi].attr    = fl_s[gi].attr;
			assign fl_nx[gi].power   = fl_s[gi].power;
			assign fl_nx[gi].total   = fl_s[gi].total;
			assign fl_nx[gi].hist    = sh_hist;
			assign fl_nx[gi].off     = sh_off;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FLUSH_STAGES; i++) begin
				fl_vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			fl_vld_s[0] <= accept && last_byte;
			for (int i = 1; i < FLUSH_STAGES; i++) begin
				fl_vld_s[i] <= fl_vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (accept && last_byte) begin
				fl_s[0] <= '{
					num_if:  num_if_n,
					cfg_val: cfg_val_n,
					attr:    attr_n,
					power:   power_n,
					total:   total_n,
					hist:    hist_n,
					off:     end_off,
					walk:    walk_n
				};
			end
			for (int i = 1; i < FLUSH_STAGES; i++) begin
				fl_s[i] <= fl_nx[i-1];
			end
		end
	end

	// result register
	flush_t fin;
	logic   fin_hv;

	assign fin    = fl_nx[FLUSH_STAGES-1];
	assign fin_hv = fin.total > 16'(HDR_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv && fl_vld_s[FLUSH_STAGES-1]) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fl_vld_s[FLUSH_STAGES-1]) begin
			header_valid       <= fin_hv;
			interface_count    <= fin_hv ? fin.num_if  : 8'd0;
			config_value       <= fin_hv ? fin.cfg_val : 8'd0;
			config_attributes  <= fin_hv ? fin.attr    : 8'd0;
			max_power          <= fin_hv ? fin.power   : 8'd0;
			interface_found    <= fin.walk.found;
			interface_number   <= fin.walk.if_number;
			interface_class    <= fin.walk.if_class;
			interface_subclass <= fin.walk.if_subclass;
			poll_interval      <= (fin.walk.interval == 8'd0) ? DEFAULT_INTERVAL
			                                                  : fin.walk.interval;
		end
	end

endmodule

>>> tb/sv/tb_usb_config_descriptor_parser_core.sv
`timescale 1ns / 1ps

module tb_usb_config_descriptor_parser_core;
	import ucdp_pkg::*;

	localparam logic [7:0] DT_CONFIGURATION = 8'd2;
	localparam logic [7:0] DT_HID           = 8'h21;
	localparam int         HOLD_CYCLES      = 300;

	typedef struct packed {
		logic       hdr_ok;
		logic [7:0] n_if;
		logic [7:0] cfg_val;
		logic [7:0] attr;
		logic [7:0] power;
		logic       if_found;
		logic [7:0] if_num;
		logic [7:0] if_cls;
		logic [7:0] if_sub;
		logic [7:0] interval;
	} summary_t;

	class descriptor_scoreboard;
		logic [7:0]  target;
		logic [7:0]  mem [BUFFER_BYTES];
		int unsigned fill;
		logic [15:0] decl_len;
		summary_t    expected_q[$];
		int          errors;

		function new();
			target = 8'd1;
			errors = 0;
			clear_store();
		endfunction

		function void clear_store();
			foreach (mem[i]) mem[i] = 8'd0;
			fill = 0;
			decl_len = 16'd0;
		endfunction

		function logic [7:0] at_offset(int unsigned p);
			return (p < BUFFER_BYTES) ? mem[p] : 8'd0;
		endfunction

		function summary_t parse_descriptor();
			summary_t    r;
			int unsigned pos;
			logic [7:0]  len;
			logic [7:0]  ep_attr;
			r = '0;
			if (decl_len > HDR_LEN) begin
				r.hdr_ok = 1'b1;
				r.n_if = at_offset(4);
				r.cfg_val = at_offset(5);
				r.attr = at_offset(7);
				r.power = at_offset(8);
				pos = HDR_LEN;
				while (pos < decl_len) begin
					len = at_offset(pos);
					if (at_offset(pos + 1) == DT_INTERFACE && at_offset(pos + 7) == target) begin
						r.if_found = 1'b1;
						r.if_num = at_offset(pos + 2);
						r.if_cls = at_offset(pos + 5);
						r.if_sub = at_offset(pos + 6);
						pos += len;
						while (pos < decl_len) begin
							ep_attr = at_offset(pos + 3);
							if (at_offset(pos + 1) == DT_INTERFACE)
								break;
							if (at_offset(pos + 1) == DT_ENDPOINT && ep_attr[1:0] == XFER_INTERRUPT) begin
								r.interval = at_offset(pos + 6);
								break;
							end
							if (at_offset(pos) == 8'd0)
								break;
							pos += at_offset(pos);
						end
						break;
					end
					if (len == 8'd0)
						break;
					pos += len;
				end
			end
			if (r.interval == 8'd0)
				r.interval = DEFAULT_INTERVAL;
			return r;
		endfunction

		function void note_transfer(logic [7:0] data, logic last);
			if (fill < BUFFER_BYTES) begin
				mem[fill] = data;
				if (fill == 2)
					decl_len[7:0] = data;
				else if (fill == 3)
					decl_len[15:8] = data;
				fill++;
			end
			if (last) begin
				expected_q.push_back(parse_descriptor());
				clear_store();
			end
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(summary_t got);
			summary_t want;
			if (expected_q.size() == 0) begin
				$display("%0t result with none expected: expected nothing, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("header_valid", want.hdr_ok, got.hdr_ok);
			compare_field("interface_count", want.n_if, got.n_if);
			compare_field("config_value", want.cfg_val, got.cfg_val);
			compare_field("config_attributes", want.attr, got.attr);
			compare_field("max_power", want.power, got.power);
			compare_field("interface_found", want.if_found, got.if_found);
			compare_field("interface_number", want.if_num, got.if_num);
			compare_field("interface_class", want.if_cls, got.if_cls);
			compare_field("interface_subclass", want.if_sub, got.if_sub);
			compare_field("poll_interval", want.interval, got.interval);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	logic       header_valid;
	logic [7:0] interface_count;
	logic [7:0] config_value;
	logic [7:0] config_attributes;
	logic [7:0] max_power;
	logic       interface_found;
	logic [7:0] interface_number;
	logic [7:0] interface_class;
	logic [7:0] interface_subclass;
	logic [7:0] poll_interval;

	descriptor_scoreboard sb;
	logic [7:0] desc[$];
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         sent_items = 0;
	logic       hold_req = 1'b0;

	usb_config_descriptor_parser_core DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.data_byte          (data_byte),
		.last_byte          (last_byte),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.header_valid       (header_valid),
		.interface_count    (interface_count),
		.config_value       (config_value),
		.config_attributes  (config_attributes),
		.max_power          (max_power),
		.interface_found    (interface_found),
		.interface_number   (interface_number),
		.interface_class    (interface_class),
		.interface_subclass (interface_subclass),
		.poll_interval      (poll_interval)
	);

	always #10 clk = ~clk;

	// receiver side, with an optional long hold-off
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({header_valid, interface_count, config_value, config_attributes,
				max_power, interface_found, interface_number, interface_class,
				interface_subclass, poll_interval});
	end

	initial begin
		#10ms;
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_transfer(input logic [7:0] data, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = data;
		last_byte = last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_transfer(data, last);
		sent_items++;
	endtask

	task automatic send_descriptor();
		if (desc.size() == 0)
			desc.push_back(8'($urandom_range(255)));
		foreach (desc[i])
			send_transfer(desc[i], i == desc.size() - 1);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (2 * FLUSH_STAGES + 2) @(posedge clk);
	endtask

	task automatic write_target(input logic [7:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.target = value;
	endtask

	function automatic logic [7:0] rand_u8();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_protocol();
		return ($urandom_range(2) != 0) ? sb.target : rand_u8();
	endfunction

	function automatic void build_header();
		desc.delete();
		repeat (9) desc.push_back(rand_u8());
		desc[0] = 8'd9;
		desc[1] = DT_CONFIGURATION;
	endfunction

	function automatic void set_total(input logic [15:0] total);
		desc[2] = total[7:0];
		desc[3] = total[15:8];
	endfunction

	function automatic void add_interface(input logic [7:0] proto);
		desc.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(12)) : 8'd9);
		desc.push_back(DT_INTERFACE);
		desc.push_back(rand_u8());
		desc.push_back(rand_u8());
		desc.push_back(8'($urandom_range(3)));
		desc.push_back(($urandom_range(1) == 0) ? 8'd3 : rand_u8());
		desc.push_back(rand_u8());
		desc.push_back(proto);
		desc.push_back(rand_u8());
	endfunction

	function automatic void add_endpoint();
		logic [7:0] attr;
		attr = rand_u8();
		if ($urandom_range(3) != 0)
			attr[1:0] = XFER_INTERRUPT;
		desc.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(12)) : 8'd7);
		desc.push_back(DT_ENDPOINT);
		desc.push_back(rand_u8());
		desc.push_back(attr);
		desc.push_back(rand_u8());
		desc.push_back(rand_u8());
		desc.push_back(($urandom_range(4) == 0) ? 8'd0 : rand_u8());
	endfunction

	function automatic void add_other();
		int n;
		if ($urandom_range(1) == 0) begin
			desc.push_back(8'd9);
			desc.push_back(DT_HID);
			repeat (7) desc.push_back(rand_u8());
		end else begin
			n = $urandom_range(12);
			desc.push_back(8'(n));
			desc.push_back(rand_u8());
			repeat (n) desc.push_back(rand_u8());
		end
	endfunction

	function automatic void build_wellformed(input int groups);
		int n;
		build_header();
		repeat (groups) begin
			add_interface(pick_protocol());
			if ($urandom_range(3) == 0)
				add_other();
			repeat ($urandom_range(2)) begin
				if ($urandom_range(5) == 0)
					add_other();
				add_endpoint();
			end
		end
		case ($urandom_range(9))
			0: set_total(16'($urandom_range(9)));
			1: set_total(16'($urandom_range(65535)));
			2: set_total(16'($urandom_range(desc.size() + 16)));
			default: set_total(16'(desc.size()));
		endcase
		if ($urandom_range(7) == 0) begin
			n = $urandom_range(1, desc.size());
			while (desc.size() > n) void'(desc.pop_back());
		end
	endfunction

	function automatic void build_noise(input int max_len);
		desc.delete();
		repeat ($urandom_range(1, max_len)) begin
			case ($urandom_range(5))
				0: desc.push_back(8'd0);
				1: desc.push_back(DT_INTERFACE);
				2: desc.push_back(DT_ENDPOINT);
				3: desc.push_back(sb.target);
				default: desc.push_back(rand_u8());
			endcase
		end
	endfunction

	// walk runs past the end of the store, a matching interface near the boundary
	function automatic void build_overflow();
		build_header();
		while (desc.size() <= BUFFER_BYTES) begin
			add_interface((desc.size() > BUFFER_BYTES - 24) ? sb.target : rand_u8());
			add_endpoint();
		end
		set_total(16'(desc.size()));
	endfunction

	task automatic run_phase(input int send_pct, input int stall_pct, input int min_items);
		int start_items;
		int descs;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		start_items = sent_items;
		descs = 0;
		while (sent_items - start_items < min_items || descs < 4) begin
			if ($urandom_range(4) == 0)
				build_noise(24);
			else
				build_wellformed($urandom_range(1, 2));
			send_descriptor();
			descs++;
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		in_valid = 1'b0;
		data_byte = 8'd0;
		last_byte = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// boot keyboard layout, zero interval on the interrupt endpoint
		desc = '{8'd9, DT_CONFIGURATION, 8'd25, 8'd0, 8'd1, 8'd1, 8'd0, 8'hA0, 8'hFA,
			8'd9, DT_INTERFACE, 8'd0, 8'd0, 8'd1, 8'd3, 8'd1, 8'd1, 8'd0,
			8'd7, DT_ENDPOINT, 8'h81, 8'd3, 8'd8, 8'd0, 8'd0};
		send_descriptor();
		desc = '{8'hFF};
		send_descriptor();

		drain_results();
		write_target(8'd2);
		run_phase(0, 0, 110);
		build_overflow();
		send_descriptor();

		drain_results();
		write_target(8'd0);
		run_phase(73, 0, 110);

		drain_results();
		write_target(8'd255);
		run_phase(0, 73, 110);

		drain_results();
		write_target(($urandom_range(1) == 0) ? 8'd1 : rand_u8());
		run_phase(32, 32, 110);

		// long receiver hold-off while short descriptors keep coming
		drain_results();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b1;
		repeat (40) begin
			build_noise(3);
			send_descriptor();
		end

		drain_results();
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
